[src/rotated_sorted_array_search_defines.svh]
// Assertion macros shared by the RTL of the rotated sorted array search.
// Depends on nothing; assumes the including module has clk and rst_n.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RSAS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define RSAS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`else
`define RSAS_ASSERT_IMPL(label, ante, cons)
`define RSAS_ASSERT_NEXT(label, ante, cons)
`define RSAS_ASSERT_ALWAYS(label, cond)
`endif

`endif

[src/rsas_pkg.sv]
// Package for the rotated sorted array search: sizes, types and command codes.
// Depends on nothing.
package rsas_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Byte address of the element count register.
    localparam logic [1:0] ADDR_ELEMENT_COUNT = 2'd0;

endpackage

[src/rotated_sorted_array_search.sv]
// Rotated sorted array search: a load item writes one store entry.
// A search item takes at most log2(DEPTH) + 1 steps before its result is valid;
// no new item is accepted until the search is back in idle;
// each step reads low, middle and high entries through the single registered read
// port of the store, then compares once. A stalled result holds the search longer.
// rst_n clears control state and element_count; the entry store has no reset.
`include "rotated_sorted_array_search_defines.svh"

module rotated_sorted_array_search (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] position, [39:8] data_value
    input  logic        s_tuser,   // [0] command
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] found_index
    output logic        m_tuser    // [0] found
);
    import rsas_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RLO  = 3'd1;
    localparam logic [2:0] S_RMID = 3'd2;
    localparam logic [2:0] S_RHI  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg;
    cnt_t       lo_reg, lo_next;
    cnt_t       hix_reg, hix_next;     // one past the high index
    cnt_t       mid_reg, mid_next;
    word_t      key_reg, key_next;
    word_t      a_lo_reg, a_lo_next;
    word_t      a_mid_reg, a_mid_next;
    logic       found_reg, found_next;
    idx_t       idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_found_reg, out_found_next;
    idx_t       out_idx_reg, out_idx_next;

    word_t      mem [DEPTH];
    word_t      rd_data_reg;
    idx_t       rd_addr;

    logic       in_accept;
    logic       cfg_write;
    cnt_t       count_clamped;
    cnt_t       span;
    cnt_t       mid_calc;
    cnt_t       hi_idx;
    word_t      a_hi;

    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_ELEMENT_COUNT) ? 32'(count_reg) : 32'd0;
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_idx_reg;
    assign m_tuser   = out_found_reg;

    assign count_clamped = (count_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : count_reg;
    assign span          = hix_reg - lo_reg - CNT_W'(1);
    assign mid_calc      = lo_reg + (span >> 1);
    assign hi_idx        = hix_reg - CNT_W'(1);
    assign a_hi          = rd_data_reg;

    always_comb
    begin
        case (state_reg)
            S_RLO:   rd_addr = lo_reg[IDX_W-1:0];
            S_RMID:  rd_addr = mid_reg[IDX_W-1:0];
            S_RHI:   rd_addr = hi_idx[IDX_W-1:0];
            default: rd_addr = lo_reg[IDX_W-1:0];
        endcase
    end

    // Entry store: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_accept && s_tuser == CMD_LOAD)
        begin
            mem[s_tdata[IDX_W-1:0]] <= s_tdata[39:8];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hix_next       = hix_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        a_lo_next      = a_lo_reg;
        a_mid_next     = a_mid_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && s_tuser == CMD_SEARCH)
                begin
                    key_next   = s_tdata[39:8];
                    lo_next    = '0;
                    hix_next   = count_clamped;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_RLO;
                end
            end
            S_RLO:
            begin
                if (lo_reg < hix_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_RMID;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RMID:
            begin
                a_lo_next  = rd_data_reg;
                state_next = S_RHI;
            end
            S_RHI:
            begin
                a_mid_next = rd_data_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_RLO;
                if (a_mid_reg == key_reg)
                begin
                    found_next = 1'b1;
                    idx_next   = mid_reg[IDX_W-1:0];
                    state_next = S_DONE;
                end
                else if (a_lo_reg <= a_mid_reg)
                begin
                    // Left half is sorted.
                    if (a_lo_reg <= key_reg && key_reg <= a_mid_reg)
                        hix_next = mid_reg;
                    else
                        lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    // Right half is sorted.
                    if (a_mid_reg <= key_reg && key_reg <= a_hi)
                        lo_next = mid_reg + CNT_W'(1);
                    else
                        hix_next = mid_reg;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_idx_next   = idx_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lo_reg        <= lo_next;
            hix_reg       <= hix_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                count_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        a_lo_reg      <= a_lo_next;
        a_mid_reg     <= a_mid_next;
        found_reg     <= found_next;
        idx_reg       <= idx_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
    end

    `RSAS_ASSERT_ALWAYS(a_range_bound, hix_reg <= CNT_W'(DEPTH))
    `RSAS_ASSERT_IMPL(a_step_range, (state_reg == S_RMID), (lo_reg < hix_reg))
    `RSAS_ASSERT_IMPL(a_mid_in_range, (state_reg == S_CMP), (mid_reg >= lo_reg && mid_reg < hix_reg))
    `RSAS_ASSERT_IMPL(a_miss_index_zero, (m_tvalid && !m_tuser), (m_tdata == '0))
    `RSAS_ASSERT_NEXT(a_result_from_done, (state_reg == S_DONE && (!out_valid_reg || m_tready)), (m_tvalid && s_tready))

endmodule
